>>> sv/lld_pkg.sv
// shared types and constants for the line lexer
`default_nettype none

package lld_pkg;

  localparam int POS_W = 13;
  localparam int START_W = 12;
  localparam logic [POS_W-1:0] MAX_LINE = 13'd4096;

  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    RK_TOKEN = 2'd0,
    RK_ERROR = 2'd1,
    RK_DONE  = 2'd2
  } result_kind_t;

  typedef enum logic [4:0] {
    TT_SYMBOL     = 5'd0,
    TT_ID         = 5'd1,
    TT_NUM        = 5'd2,
    TT_STRING     = 5'd3,
    TT_PLUS       = 5'd4,
    TT_MINUS      = 5'd5,
    TT_LPAREN     = 5'd6,
    TT_RPAREN     = 5'd7,
    TT_LBRACE     = 5'd8,
    TT_RBRACE     = 5'd9,
    TT_LBRACK     = 5'd10,
    TT_RBRACK     = 5'd11,
    TT_SEMICOLON  = 5'd12,
    TT_COMMA      = 5'd13,
    TT_EQUALS     = 5'd14,
    TT_WHITESPACE = 5'd15,
    TT_COMMENT    = 5'd16
  } token_type_t;

  typedef enum logic [1:0] {
    EC_BAD_BYTE   = 2'd0,
    EC_NUM_LETTER = 2'd1,
    EC_UNFINISHED = 2'd2,
    EC_TOO_LONG   = 2'd3
  } error_code_t;

  typedef enum logic [0:0] {
    IK_BYTE = 1'b0,
    IK_EOL  = 1'b1
  } item_kind_t;

  typedef enum logic [4:0] {
    CC_ALPHA,
    CC_DIGIT,
    CC_BQUOTE,
    CC_SQUOTE,
    CC_DQUOTE,
    CC_BSLASH,
    CC_SPACE,
    CC_HASH,
    CC_UNDER,
    CC_DOT,
    CC_PLUS,
    CC_MINUS,
    CC_LPAREN,
    CC_RPAREN,
    CC_LBRACE,
    CC_RBRACE,
    CC_LBRACK,
    CC_RBRACK,
    CC_SEMI,
    CC_COMMA,
    CC_EQUALS,
    CC_OTHER,
    CC_EOL
  } char_class_t;

  typedef enum logic [4:0] {
    ST_START  = 5'd0,
    ST_SYM    = 5'd1,
    ST_ID     = 5'd2,
    ST_INT    = 5'd3,
    ST_DEC    = 5'd4,
    ST_SQ     = 5'd5,
    ST_SQE    = 5'd6,
    ST_DQ     = 5'd7,
    ST_DQE    = 5'd8,
    ST_STREND = 5'd9,
    ST_WS     = 5'd10,
    ST_CMT    = 5'd11,
    ST_PLUS   = 5'd12,
    ST_MINUS  = 5'd13,
    ST_LPAREN = 5'd14,
    ST_RPAREN = 5'd15,
    ST_LBRACE = 5'd16,
    ST_RBRACE = 5'd17,
    ST_LBRACK = 5'd18,
    ST_RBRACK = 5'd19,
    ST_SEMI   = 5'd20,
    ST_COMMA  = 5'd21,
    ST_EQUALS = 5'd22,
    NX_FAIL   = 5'd30,
    NX_HARD   = 5'd31
  } lex_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [4:0]         token_type;
    logic [START_W-1:0] token_start;
    logic [POS_W-1:0]   token_length;
    logic [1:0]         error_code;
    logic [POS_W-1:0]   error_position;
    logic               last;
  } result_t;

  typedef struct packed {
    logic        valid;
    char_class_t cls;
  } head_t;

endpackage

`default_nettype wire

>>> sv/lld_front.sv
// front end: accepts bytes, classifies them and queues the classes
`default_nettype none

module lld_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire lld_pkg::item_t item,
  output lld_pkg::head_t     head,
  input  wire logic          pop
);
  import lld_pkg::*;

  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cc;
    cc = CC_OTHER;
    if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) begin
      cc = CC_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cc = CC_DIGIT;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cc = CC_SPACE;
    end else begin
      case (c)
        CH_BQUOTE: cc = CC_BQUOTE;
        CH_SQUOTE: cc = CC_SQUOTE;
        CH_DQUOTE: cc = CC_DQUOTE;
        CH_BSLASH: cc = CC_BSLASH;
        CH_HASH:   cc = CC_HASH;
        CH_UNDER:  cc = CC_UNDER;
        CH_DOT:    cc = CC_DOT;
        CH_PLUS:   cc = CC_PLUS;
        CH_MINUS:  cc = CC_MINUS;
        CH_LPAREN: cc = CC_LPAREN;
        CH_RPAREN: cc = CC_RPAREN;
        CH_LBRACE: cc = CC_LBRACE;
        CH_RBRACE: cc = CC_RBRACE;
        CH_LBRACK: cc = CC_LBRACK;
        CH_RBRACK: cc = CC_RBRACK;
        CH_SEMI:   cc = CC_SEMI;
        CH_COMMA:  cc = CC_COMMA;
        CH_EQUALS: cc = CC_EQUALS;
        default:   cc = CC_OTHER;
      endcase
    end
    return cc;
  endfunction

  char_class_t       queue [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              do_pop;
  char_class_t       cls_in;

  assign item_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && item_ready;
  assign do_pop     = pop && (count != '0);
  assign cls_in     = (item.kind == IK_EOL) ? CC_EOL : classify(item.char_code);

  assign head = '{valid: (count != '0), cls: queue[rd_ptr]};

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/lld_back.sv
// back end: dfa step, token, error and line-done results, result register
`default_nettype none

module lld_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lld_pkg::head_t head,
  output logic                pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output lld_pkg::result_t    res
);
  import lld_pkg::*;

  typedef struct packed {
    logic        ok;
    token_type_t ttype;
  } accept_t;

  function automatic lex_state_t lex_next(input lex_state_t st, input char_class_t cc);
    lex_state_t nx;
    nx = NX_FAIL;
    case (st)
      ST_START: begin
        case (cc)
          CC_ALPHA:  nx = ST_ID;
          CC_DIGIT:  nx = ST_INT;
          CC_BQUOTE: nx = ST_SYM;
          CC_SQUOTE: nx = ST_SQ;
          CC_DQUOTE: nx = ST_DQ;
          CC_SPACE:  nx = ST_WS;
          CC_HASH:   nx = ST_CMT;
          CC_PLUS:   nx = ST_PLUS;
          CC_MINUS:  nx = ST_MINUS;
          CC_LPAREN: nx = ST_LPAREN;
          CC_RPAREN: nx = ST_RPAREN;
          CC_LBRACE: nx = ST_LBRACE;
          CC_RBRACE: nx = ST_RBRACE;
          CC_LBRACK: nx = ST_LBRACK;
          CC_RBRACK: nx = ST_RBRACK;
          CC_SEMI:   nx = ST_SEMI;
          CC_COMMA:  nx = ST_COMMA;
          CC_EQUALS: nx = ST_EQUALS;
          default:   nx = NX_FAIL;
        endcase
      end
      ST_SYM: begin
        nx = (cc == CC_ALPHA || cc == CC_DIGIT || cc == CC_UNDER) ? ST_SYM : NX_FAIL;
      end
      ST_ID: begin
        nx = (cc == CC_ALPHA || cc == CC_DIGIT) ? ST_ID : NX_FAIL;
      end
      ST_INT: begin
        if (cc == CC_DIGIT) begin
          nx = ST_INT;
        end else if (cc == CC_DOT) begin
          nx = ST_DEC;
        end else begin
          nx = (cc == CC_ALPHA) ? NX_HARD : NX_FAIL;
        end
      end
      ST_DEC: begin
        if (cc == CC_DIGIT) begin
          nx = ST_DEC;
        end else begin
          nx = (cc == CC_ALPHA) ? NX_HARD : NX_FAIL;
        end
      end
      ST_SQ: begin
        if (cc == CC_SQUOTE) begin
          nx = ST_STREND;
        end else begin
          nx = (cc == CC_BSLASH) ? ST_SQE : ST_SQ;
        end
      end
      ST_SQE: nx = ST_SQ;
      ST_DQ: begin
        if (cc == CC_DQUOTE) begin
          nx = ST_STREND;
        end else begin
          nx = (cc == CC_BSLASH) ? ST_DQE : ST_DQ;
        end
      end
      ST_DQE: nx = ST_DQ;
      ST_WS:  nx = (cc == CC_SPACE) ? ST_WS : NX_FAIL;
      ST_CMT: nx = ST_CMT;
      default: nx = NX_FAIL;
    endcase
    return nx;
  endfunction

  function automatic accept_t accept_of(input lex_state_t st);
    accept_t a;
    a.ok    = 1'b1;
    a.ttype = TT_SYMBOL;
    case (st)
      ST_SYM:    a.ttype = TT_SYMBOL;
      ST_ID:     a.ttype = TT_ID;
      ST_INT:    a.ttype = TT_NUM;
      ST_DEC:    a.ttype = TT_NUM;
      ST_STREND: a.ttype = TT_STRING;
      ST_WS:     a.ttype = TT_WHITESPACE;
      ST_CMT:    a.ttype = TT_COMMENT;
      ST_PLUS:   a.ttype = TT_PLUS;
      ST_MINUS:  a.ttype = TT_MINUS;
      ST_LPAREN: a.ttype = TT_LPAREN;
      ST_RPAREN: a.ttype = TT_RPAREN;
      ST_LBRACE: a.ttype = TT_LBRACE;
      ST_RBRACE: a.ttype = TT_RBRACE;
      ST_LBRACK: a.ttype = TT_LBRACK;
      ST_RBRACK: a.ttype = TT_RBRACK;
      ST_SEMI:   a.ttype = TT_SEMICOLON;
      ST_COMMA:  a.ttype = TT_COMMA;
      ST_EQUALS: a.ttype = TT_EQUALS;
      default:   a.ok = 1'b0;
    endcase
    return a;
  endfunction

  lex_state_t         state;
  lex_state_t         state_next;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   position_next;
  logic [START_W-1:0] tok_start;
  logic [START_W-1:0] tok_start_next;
  logic               halted;
  logic               halted_next;

  result_t    r0;
  result_t    r1;
  result_t    tok;
  logic [1:0] nres;
  lex_state_t nx;
  lex_state_t nx2;
  accept_t    acc;

  result_t pend;
  logic    pend_valid;
  logic    slot_free;

  assign slot_free = !res_valid || res_ready;
  assign pop       = head.valid && !pend_valid && slot_free;

  always_comb begin
    state_next        = state;
    position_next     = position;
    tok_start_next    = tok_start;
    halted_next       = halted;
    r0                = '0;
    r1                = '0;
    nres              = 2'd0;
    acc               = accept_of(state);
    nx                = lex_next(state, head.cls);
    nx2               = lex_next(ST_START, head.cls);
    tok               = '0;
    tok.result_kind   = RK_TOKEN;
    tok.token_type    = acc.ttype;
    tok.token_start   = tok_start;
    tok.token_length  = position - {1'b0, tok_start};

    if (head.cls == CC_EOL) begin
      if (!halted) begin
        if (state == ST_START) begin
          r0.result_kind = RK_DONE;
          r0.last        = 1'b1;
          nres           = 2'd1;
        end else if (acc.ok) begin
          r0             = tok;
          r1.result_kind = RK_DONE;
          r1.last        = 1'b1;
          nres           = 2'd2;
        end else begin
          r0.result_kind    = RK_ERROR;
          r0.error_code     = EC_UNFINISHED;
          r0.error_position = position;
          r0.last           = 1'b1;
          nres              = 2'd1;
        end
      end
      state_next        = ST_START;
      position_next     = '0;
      tok_start_next    = '0;
      halted_next       = 1'b0;
    end else if (!halted) begin
      if (position >= MAX_LINE) begin
        r0.result_kind    = RK_ERROR;
        r0.error_code     = EC_TOO_LONG;
        r0.error_position = position;
        r0.last           = 1'b1;
        nres              = 2'd1;
        halted_next       = 1'b1;
        state_next        = ST_START;
      end else if (nx == NX_HARD) begin
        r0.result_kind    = RK_ERROR;
        r0.error_code     = EC_NUM_LETTER;
        r0.error_position = position;
        r0.last           = 1'b1;
        nres              = 2'd1;
        halted_next       = 1'b1;
        state_next        = ST_START;
      end else if (nx == NX_FAIL) begin
        if (acc.ok) begin
          tok_start_next = position[START_W-1:0];
          if (nx2 == NX_FAIL || nx2 == NX_HARD) begin
            r0                = tok;
            r1.result_kind    = RK_ERROR;
            r1.error_code     = EC_BAD_BYTE;
            r1.error_position = position;
            r1.last           = 1'b1;
            nres              = 2'd2;
            halted_next       = 1'b1;
            state_next        = ST_START;
          end else begin
            r0            = tok;
            r0.last       = 1'b1;
            nres          = 2'd1;
            state_next    = nx2;
            position_next = position + 1'b1;
          end
        end else begin
          r0.result_kind    = RK_ERROR;
          r0.error_code     = EC_BAD_BYTE;
          r0.error_position = position;
          r0.last           = 1'b1;
          nres              = 2'd1;
          halted_next       = 1'b1;
          state_next        = ST_START;
        end
      end else begin
        state_next    = nx;
        position_next = position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      position  <= '0;
      tok_start <= '0;
      halted    <= 1'b0;
    end else if (pop) begin
      state     <= state_next;
      position  <= position_next;
      tok_start <= tok_start_next;
      halted    <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        res_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (pop && nres != 2'd0) begin
        res_valid  <= 1'b1;
        pend_valid <= (nres == 2'd2);
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        res <= pend;
      end else if (pop && nres != 2'd0) begin
        res  <= r0;
        pend <= r1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/line_lexer_dfa_top.sv
// top level of the line lexer: classifier front end, queue, dfa back end
`default_nettype none

// Takes one line of text a byte per transfer, closed by an end-of-line
// transfer, and returns tokens with start and length, errors, and a
// line-done mark. With the result side ready and no two-result hold, a new
// byte is taken every cycle. A byte or end of line that yields two results
// (a token followed by an error or by line done) holds the back end while the
// second result waits in a pending register, since the single result register
// sends one result per cycle; a two-entry queue between the classifier and the
// dfa buffers bytes through that hold and any short stall on either side.
// Results are registered. No clearing pass is needed after reset.
module line_lexer_dfa_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire lld_pkg::item_t item,
  output logic                res_valid,
  input  wire logic           res_ready,
  output lld_pkg::result_t    res
);
  import lld_pkg::*;

  head_t head;
  logic  pop;

  lld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .head       (head),
    .pop        (pop)
  );

  lld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

>>> sv/lld_checker.sv
// port-level checks for the line lexer and their binding
`default_nettype none

module lld_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire lld_pkg::item_t   item,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire lld_pkg::result_t res
);
  import lld_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("waiting input transfer changed");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind != RK_TOKEN |->
      res.token_type == '0 && res.token_start == '0 && res.token_length == '0)
    else $error("token fields set on non-token result");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind == RK_DONE |-> res.last && res.error_code == '0)
    else $error("line done result not last");

endmodule

bind line_lexer_dfa_top lld_checker u_lld_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .item       (item),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res)
);

`default_nettype wire
